// File: design/atu_pkg.sv
// Shared types, codes and constants of the affine transform unit.
package atu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int MAT_ENTRIES   = 12;
	localparam int ADDR_W        = 4;

	typedef enum logic [2:0] {
		FN_IDENT = 3'd0,
		FN_TRANS = 3'd1,
		FN_SCALE = 3'd2,
		FN_SHEAR = 3'd3,
		FN_XFORM = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic [2:0]               func;
		logic signed [DATA_W-1:0] op_a;
		logic signed [DATA_W-1:0] op_b;
		logic signed [DATA_W-1:0] op_c;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
	} out_item_t;

	// Control that travels alongside one multiply-accumulate step.
	typedef struct packed {
		logic              first;
		logic              wr;
		logic              out_wr;
		logic [ADDR_W-1:0] addr;
		logic [1:0]        col;
	} mac_ctrl_t;

endpackage

// File: design/affine_transform_unit_core.sv
// Top level of the affine transform unit: matrix store, sequencer and result register.
//
//  Channel   Signals                              Transfer moves
//  -------   ----------------------------------   -----------------------------
//  item      item_valid, item_stall, item         one operation and 3 operands
//  result    result_valid, result_stall, result   one transformed point
//
// Translate takes 6 steps of the shared multiply-accumulate unit, scale, shear and transform
// take 12; a flush state then drains the unit, and a transform adds a push state to hand its
// point on before the next item is taken; identity and unused codes stay in the idle state.
// Reset loads the identity matrix and empties the pipeline and the result register.
// A finished point waits in its own stage while the result register is still stalled, which
// adds those stall cycles to a transform; new items are taken once the point has moved on.
module affine_transform_unit_core import atu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	// Unity in the chosen fixed-point format; a step that multiplies by it passes its
	// other operand through the unit unchanged.
	localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

	state_t state_q, state_d;

	in_item_t                 item_q;
	logic [1:0]               inner_q;
	logic [1:0]               outer_q;
	logic signed [DATA_W-1:0] mat_q [MAT_ENTRIES];
	logic signed [DATA_W-1:0] res_q [3];
	logic                     result_valid_q;
	out_item_t                result_q;

	logic                     accept;
	logic                     push;
	logic                     issue;
	logic [1:0]               inner_max;
	logic [1:0]               outer_max;
	logic                     last;
	logic                     a_mat;
	logic                     b_one;
	logic [1:0]               opsel;
	mac_ctrl_t                ctrl;
	logic signed [DATA_W-1:0] op_val;
	logic signed [DATA_W-1:0] mac_a;
	logic signed [DATA_W-1:0] mac_b;
	logic                     done_valid;
	mac_ctrl_t                done_ctrl;
	logic signed [DATA_W-1:0] acc;
	logic [ADDR_W-1:0]        row_base;

	assign accept = item_valid && !item_stall;
	assign issue  = (state_q == ST_RUN);

	// Step decode. The outer counter walks rows or columns, the inner counter walks the
	// steps inside one of them; the matrix address comes from both.
	always_comb begin
		inner_max   = 2'd2;
		outer_max   = 2'd3;
		a_mat       = 1'b1;
		b_one       = 1'b0;
		opsel       = inner_q;
		ctrl.first  = (inner_q == 2'd0);
		ctrl.wr     = 1'b0;
		ctrl.out_wr = 1'b0;
		ctrl.col    = outer_q;
		row_base    = ({2'b00, outer_q} << 1) + {2'b00, outer_q};
		ctrl.addr   = row_base + {2'b00, inner_q};
		case (func_t'(item_q.func))
			FN_SCALE: begin
				ctrl.first = 1'b1;
				ctrl.wr    = 1'b1;
			end
			FN_TRANS: begin
				inner_max = 2'd1;
				outer_max = 2'd2;
				opsel     = outer_q;
				b_one     = 1'b1;
				ctrl.addr = ADDR_W'(9) + {2'b00, outer_q};
				a_mat     = (inner_q == 2'd1);
				ctrl.wr   = (inner_q == 2'd1);
			end
			FN_SHEAR: begin
				b_one   = (inner_q == 2'd2);
				ctrl.wr = (inner_q == 2'd2);
			end
			FN_XFORM: begin
				inner_max   = 2'd3;
				outer_max   = 2'd2;
				ctrl.addr   = ({2'b00, inner_q} << 1) + {2'b00, inner_q} + {2'b00, outer_q};
				b_one       = (inner_q == 2'd3);
				ctrl.out_wr = (inner_q == 2'd3);
			end
			default: begin
				inner_max = 2'd0;
				outer_max = 2'd0;
			end
		endcase
		last = (inner_q == inner_max) && (outer_q == outer_max);
	end

	always_comb begin
		case (opsel)
			2'd0:    op_val = item_q.op_a;
			2'd1:    op_val = item_q.op_b;
			default: op_val = item_q.op_c;
		endcase
		mac_a = a_mat ? mat_q[ctrl.addr] : op_val;
		mac_b = b_one ? ONE : op_val;
	end

	atu_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.a         (mac_a),
		.b         (mac_b),
		.ctrl      (ctrl),
		.done_valid(done_valid),
		.done_ctrl (done_ctrl),
		.acc       (acc)
	);

	// Sequencer: run the steps, let the last one leave the unit, then hand off a point.
	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func_t'(item.func))
						FN_TRANS, FN_SCALE, FN_SHEAR, FN_XFORM: state_d = ST_RUN;
						default:                                state_d = ST_IDLE;
					endcase
				end
			end
			ST_RUN: begin
				if (last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = (func_t'(item_q.func) == FN_XFORM) ? ST_PUSH : ST_IDLE;
			end
			ST_PUSH: begin
				if (!result_valid_q || !result_stall) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			inner_q        <= 2'd0;
			outer_q        <= 2'd0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				inner_q <= 2'd0;
				outer_q <= 2'd0;
			end else if (issue) begin
				if (inner_q == inner_max) begin
					inner_q <= 2'd0;
					outer_q <= outer_q + 2'd1;
				end else begin
					inner_q <= inner_q + 2'd1;
				end
			end
			if (push) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// The matrix resets to the identity; an identity item reloads it when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_ENTRIES; i++) begin
				mat_q[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
			end
		end else if (accept && func_t'(item.func) == FN_IDENT) begin
			for (int i = 0; i < MAT_ENTRIES; i++) begin
				mat_q[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
			end
		end else if (done_valid && done_ctrl.wr) begin
			mat_q[done_ctrl.addr] <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (done_valid && done_ctrl.out_wr) begin
			res_q[done_ctrl.col] <= acc;
		end
		if (push) begin
			result_q.out_x <= res_q[0];
			result_q.out_y <= res_q[1];
			result_q.out_z <= res_q[2];
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: design/atu_mac.sv
// Shared two-stage multiply, round, saturate and accumulate unit.
module atu_mac import atu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     issue,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W-1:0] b,
	input  mac_ctrl_t                ctrl,
	output logic                     done_valid,
	output mac_ctrl_t                done_ctrl,
	output logic signed [DATA_W-1:0] acc
);

	localparam logic signed [2*DATA_W-1:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic                       v_s1;
	logic signed [2*DATA_W-1:0] prod_s1;
	mac_ctrl_t                  ctrl_s1;
	logic signed [DATA_W-1:0]   acc_q;

	logic signed [2*DATA_W-1:0] rnd;
	logic signed [2*DATA_W-1:0] quo;
	logic signed [DATA_W-1:0]   term;
	logic signed [DATA_W:0]     sum;
	logic signed [DATA_W-1:0]   acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= a * b;
			ctrl_s1 <= ctrl;
		end
		if (v_s1) begin
			acc_q <= acc_next;
		end
	end

	// Round half up, floor shift, then clamp when the upper bits are not all sign.
	always_comb begin
		rnd = prod_s1 + RND;
		quo = rnd >>> FRAC_BITS;
		if (quo[2*DATA_W-1:DATA_W-1] == '0 || quo[2*DATA_W-1:DATA_W-1] == '1) begin
			term = quo[DATA_W-1:0];
		end else begin
			term = quo[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
		end
		sum = {acc_q[DATA_W-1], acc_q} + {term[DATA_W-1], term};
		if (ctrl_s1.first) begin
			acc_next = term;
		end else if (sum[DATA_W] != sum[DATA_W-1]) begin
			acc_next = sum[DATA_W] ? SAT_MIN : SAT_MAX;
		end else begin
			acc_next = sum[DATA_W-1:0];
		end
	end

	assign done_valid = v_s1;
	assign done_ctrl  = ctrl_s1;
	assign acc        = acc_next;

endmodule

// File: design/atu_checker.sv
// Port-level checks for the affine transform unit, bound to its top level.
module atu_checker import atu_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	// A stalled result holds its value until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// A transform keeps the block busy in the following cycle.
	a_xform_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.func == FN_XFORM |=> item_stall)
		else $error("block free right after a transform transfer");

	// Identity completes in the cycle of its transfer.
	a_ident_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.func == FN_IDENT |=> !item_stall)
		else $error("identity kept the block busy");

	// A new result only appears at the end of a busy period.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without work in progress");

endmodule

bind affine_transform_unit_core atu_checker u_atu_checker (.*);
